// File: hw/rtl/vnem_pkg.sv
package vnem_pkg;

    // Vector length limit and element counter width (counter saturates at MAX_ITEMS + 1)
    localparam int MAX_ITEMS = 1024;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 2);

    // Element and accumulator widths, Q12.12 in, Q.12 sums, Q.24 sums of squares
    localparam int IN_W   = 24;
    localparam int DABS_W = IN_W + 1;
    localparam int EABS_W = IN_W;
    localparam int DSQ_W  = 2 * DABS_W - 1;
    localparam int ESQ_W  = 2 * EABS_W - 1;
    localparam int SUM_W  = 35;
    localparam int SQS_W  = 59;

    localparam int OUT_W  = 32;
    localparam int STAT_W = 2;
    localparam int SEL_W  = 2;

    // Job queue between accumulate front and finish back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [SEL_W-1:0] NORM_ONE = 2'd0;
    localparam logic [SEL_W-1:0] NORM_TWO = 2'd1;

    // One finished vector: selected numerator and denominator sums or maxima
    typedef struct packed {
        logic             two_norm;
        logic             rel;
        logic             over;
        logic [SQS_W-1:0] num;
        logic [SQS_W-1:0] den;
    } job_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

// File: hw/rtl/vnem_front.sv
module vnem_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [vnem_pkg::IN_W-1:0] s_approx_value,
    input  logic signed [vnem_pkg::IN_W-1:0] s_exact_value,
    input  logic                           s_last_item,
    input  logic [vnem_pkg::SEL_W-1:0]     norm_sel,
    input  logic                           rel_mode,
    input  vnem_pkg::q_stat_t              q_stat,
    output logic                           push,
    output vnem_pkg::job_t                 push_job
);

    logic                            accept;
    logic [vnem_pkg::QCNT_W:0]       busy;
    logic [vnem_pkg::DABS_W-1:0]     d_u;
    logic [vnem_pkg::DABS_W-1:0]     dabs;
    logic [vnem_pkg::EABS_W-1:0]     e_u;
    logic [vnem_pkg::EABS_W-1:0]     eabs;
    logic                            acc_en;
    logic [2*vnem_pkg::DABS_W-1:0]   dsq_full;
    logic [2*vnem_pkg::EABS_W-1:0]   esq_full;

    logic [vnem_pkg::CNT_W-1:0]      cnt_reg;
    logic [vnem_pkg::CNT_W-1:0]      cnt_next;

    logic                            s1_vld_reg;
    logic                            s1_last_reg;
    logic                            s1_en_reg;
    logic                            s1_over_reg;
    logic [vnem_pkg::DABS_W-1:0]     s1_dabs_reg;
    logic [vnem_pkg::EABS_W-1:0]     s1_eabs_reg;

    logic                            s2_vld_reg;
    logic                            s2_last_reg;
    logic                            s2_en_reg;
    logic                            s2_over_reg;
    logic [vnem_pkg::DABS_W-1:0]     s2_dabs_reg;
    logic [vnem_pkg::EABS_W-1:0]     s2_eabs_reg;
    logic [vnem_pkg::DSQ_W-1:0]      s2_dsq_reg;
    logic [vnem_pkg::ESQ_W-1:0]      s2_esq_reg;

    logic [vnem_pkg::SUM_W-1:0]      dsum_reg;
    logic [vnem_pkg::SUM_W-1:0]      dsum_next;
    logic [vnem_pkg::SUM_W-1:0]      esum_reg;
    logic [vnem_pkg::SUM_W-1:0]      esum_next;
    logic [vnem_pkg::SQS_W-1:0]      dsqs_reg;
    logic [vnem_pkg::SQS_W-1:0]      dsqs_next;
    logic [vnem_pkg::SQS_W-1:0]      esqs_reg;
    logic [vnem_pkg::SQS_W-1:0]      esqs_next;
    logic [vnem_pkg::DABS_W-1:0]     dmax_reg;
    logic [vnem_pkg::DABS_W-1:0]     dmax_next;
    logic [vnem_pkg::EABS_W-1:0]     emax_reg;
    logic [vnem_pkg::EABS_W-1:0]     emax_next;

    // Hold off new words while queued jobs plus pending last words fill every queue slot
    assign busy = {1'b0, q_stat.count}
                + (vnem_pkg::QCNT_W + 1)'(s1_vld_reg & s1_last_reg)
                + (vnem_pkg::QCNT_W + 1)'(s2_vld_reg & s2_last_reg);
    assign s_ready = busy < (vnem_pkg::QCNT_W + 1)'(vnem_pkg::QDEPTH);
    assign accept  = s_valid & s_ready;

    assign d_u  = {s_approx_value[vnem_pkg::IN_W-1], s_approx_value}
                - {s_exact_value[vnem_pkg::IN_W-1], s_exact_value};
    assign dabs = d_u[vnem_pkg::DABS_W-1] ? (~d_u + 1'b1) : d_u;
    assign e_u  = s_exact_value;
    assign eabs = e_u[vnem_pkg::EABS_W-1] ? (~e_u + 1'b1) : e_u;

    assign acc_en = cnt_reg < vnem_pkg::CNT_W'(vnem_pkg::MAX_ITEMS);

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_last_item) begin
                cnt_next = '0;
            end else if (cnt_reg <= vnem_pkg::CNT_W'(vnem_pkg::MAX_ITEMS)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign dsq_full = s1_dabs_reg * s1_dabs_reg;
    assign esq_full = s1_eabs_reg * s1_eabs_reg;

    always_comb begin
        dsum_next = dsum_reg;
        esum_next = esum_reg;
        dsqs_next = dsqs_reg;
        esqs_next = esqs_reg;
        dmax_next = dmax_reg;
        emax_next = emax_reg;
        if (s2_vld_reg && s2_en_reg) begin
            dsum_next = dsum_reg + vnem_pkg::SUM_W'(s2_dabs_reg);
            esum_next = esum_reg + vnem_pkg::SUM_W'(s2_eabs_reg);
            dsqs_next = dsqs_reg + vnem_pkg::SQS_W'(s2_dsq_reg);
            esqs_next = esqs_reg + vnem_pkg::SQS_W'(s2_esq_reg);
            if (s2_dabs_reg > dmax_reg) begin
                dmax_next = s2_dabs_reg;
            end
            if (s2_eabs_reg > emax_reg) begin
                emax_next = s2_eabs_reg;
            end
        end
    end

    // Pick the numerator and denominator of the selected norm
    assign push = s2_vld_reg & s2_last_reg;

    always_comb begin
        push_job.two_norm = (norm_sel == vnem_pkg::NORM_TWO);
        push_job.rel      = rel_mode;
        push_job.over     = s2_over_reg;
        if (norm_sel == vnem_pkg::NORM_TWO) begin
            push_job.num = dsqs_next;
            push_job.den = esqs_next;
        end else if (norm_sel == vnem_pkg::NORM_ONE) begin
            push_job.num = vnem_pkg::SQS_W'(dsum_next);
            push_job.den = vnem_pkg::SQS_W'(esum_next);
        end else begin
            push_job.num = vnem_pkg::SQS_W'(dmax_next);
            push_job.den = vnem_pkg::SQS_W'(emax_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            dsum_reg   <= '0;
            esum_reg   <= '0;
            dsqs_reg   <= '0;
            esqs_reg   <= '0;
            dmax_reg   <= '0;
            emax_reg   <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            if (push) begin
                dsum_reg <= '0;
                esum_reg <= '0;
                dsqs_reg <= '0;
                esqs_reg <= '0;
                dmax_reg <= '0;
                emax_reg <= '0;
            end else begin
                dsum_reg <= dsum_next;
                esum_reg <= esum_next;
                dsqs_reg <= dsqs_next;
                esqs_reg <= esqs_next;
                dmax_reg <= dmax_next;
                emax_reg <= emax_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_last_reg <= s_last_item;
        s1_en_reg   <= acc_en;
        s1_over_reg <= ~acc_en;
        s1_dabs_reg <= dabs;
        s1_eabs_reg <= eabs;
        s2_last_reg <= s1_last_reg;
        s2_en_reg   <= s1_en_reg;
        s2_over_reg <= s1_over_reg;
        s2_dabs_reg <= s1_dabs_reg;
        s2_eabs_reg <= s1_eabs_reg;
        s2_dsq_reg  <= vnem_pkg::DSQ_W'(dsq_full);
        s2_esq_reg  <= vnem_pkg::ESQ_W'(esq_full);
    end

endmodule

// File: hw/rtl/vnem_queue.sv
module vnem_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vnem_pkg::job_t    push_job,
    input  logic              pop,
    output vnem_pkg::job_t    pop_job,
    output vnem_pkg::q_stat_t q_stat
);

    vnem_pkg::job_t              mem_reg [vnem_pkg::QDEPTH];
    logic [vnem_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vnem_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [vnem_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vnem_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [vnem_pkg::QCNT_W-1:0] count_reg;
    logic [vnem_pkg::QCNT_W-1:0] count_next;

    localparam logic [vnem_pkg::QPTR_W-1:0] PTR_LAST = vnem_pkg::QPTR_W'(vnem_pkg::QDEPTH - 1);

    assign pop_job      = mem_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/vnem_back.sv
module vnem_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vnem_pkg::q_stat_t              q_stat,
    input  vnem_pkg::job_t                 job,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vnem_pkg::OUT_W-1:0]     m_error_value,
    output logic [vnem_pkg::STAT_W-1:0]    m_error_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [vnem_pkg::STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [vnem_pkg::STAT_W-1:0] STAT_ZDEN = 2'd1;
    localparam logic [vnem_pkg::STAT_W-1:0] STAT_SAT  = 2'd2;

    localparam int REM_W    = vnem_pkg::SQS_W;
    localparam int SHF_W    = 64;
    localparam int ROOT_W   = vnem_pkg::OUT_W;
    localparam int SQR_W    = ROOT_W + 2;
    localparam int LIN_SH   = 16;
    localparam int TWO_SH   = 32;
    localparam int ABS_SH   = 4;
    localparam int SQ_SH    = 8;
    localparam int DIV_LIN  = 32;
    localparam int DIV_TWO  = 64;
    localparam int SQ_STEPS = ROOT_W;
    localparam int ITER_W   = $clog2(DIV_TWO + 1);

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [REM_W-1:0]               rem_reg;
    logic [REM_W-1:0]               rem_next;
    logic [REM_W-1:0]               den_reg;
    logic [REM_W-1:0]               den_next;
    logic [SHF_W-1:0]               shf_reg;
    logic [SHF_W-1:0]               shf_next;
    logic [SHF_W-1:0]               quo_reg;
    logic [SHF_W-1:0]               quo_next;
    logic [SQR_W-1:0]               sq_rem_reg;
    logic [SQR_W-1:0]               sq_rem_next;
    logic [ROOT_W-1:0]              root_reg;
    logic [ROOT_W-1:0]              root_next;
    logic [ITER_W-1:0]              iter_reg;
    logic [ITER_W-1:0]              iter_next;
    logic                           sqrt_after_reg;
    logic                           sqrt_after_next;
    logic                           over_reg;
    logic                           over_next;
    logic [vnem_pkg::OUT_W-1:0]     val_reg;
    logic [vnem_pkg::OUT_W-1:0]     val_next;
    logic [vnem_pkg::STAT_W-1:0]    stat_reg;
    logic [vnem_pkg::STAT_W-1:0]    stat_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [vnem_pkg::OUT_W-1:0]     m_value_reg;
    logic [vnem_pkg::OUT_W-1:0]     m_value_next;
    logic [vnem_pkg::STAT_W-1:0]    m_stat_reg;
    logic [vnem_pkg::STAT_W-1:0]    m_stat_next;

    logic                           zden;
    logic                           ovf;
    logic [REM_W:0]                 div_r2;
    logic                           div_ge;
    logic [REM_W:0]                 div_diff;
    logic [SHF_W-1:0]               quo_step;
    logic [SQR_W+1:0]               sq_r2;
    logic [SQR_W+1:0]               sq_trial;
    logic                           sq_ge;
    logic [SQR_W+1:0]               sq_diff;
    logic [ROOT_W-1:0]              root_step;

    assign m_valid        = m_valid_reg;
    assign m_error_value  = m_value_reg;
    assign m_error_status = m_stat_reg;

    // Classify the job at the queue head
    assign zden = job.rel && (job.den == '0);

    always_comb begin
        if (job.two_norm) begin
            ovf = job.rel ? ((job.num >> TWO_SH) >= job.den) : ((job.num >> 56) != '0);
        end else begin
            ovf = job.rel ? ((job.num >> LIN_SH) >= job.den) : ((job.num >> 28) != '0);
        end
    end

    // One restoring divide step and one square-root digit step
    assign div_r2   = {rem_reg, shf_reg[SHF_W-1]};
    assign div_diff = div_r2 - {1'b0, den_reg};
    assign div_ge   = div_r2 >= {1'b0, den_reg};
    assign quo_step = {quo_reg[SHF_W-2:0], div_ge};

    assign sq_r2     = {sq_rem_reg, shf_reg[SHF_W-1:SHF_W-2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = sq_r2 >= sq_trial;
    assign sq_diff   = sq_r2 - sq_trial;
    assign root_step = {root_reg[ROOT_W-2:0], sq_ge};

    always_comb begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        shf_next        = shf_reg;
        quo_next        = quo_reg;
        sq_rem_next     = sq_rem_reg;
        root_next       = root_reg;
        iter_next       = iter_reg;
        sqrt_after_next = sqrt_after_reg;
        over_next       = over_reg;
        val_next        = val_reg;
        stat_next       = stat_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_stat_next     = m_stat_reg;
        pop             = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop       = 1'b1;
                    over_next = job.over;
                    if (zden) begin
                        val_next   = '0;
                        stat_next  = STAT_ZDEN;
                        state_next = ST_DONE;
                    end else if (ovf) begin
                        val_next   = '1;
                        stat_next  = STAT_SAT;
                        state_next = ST_DONE;
                    end else if (!job.two_norm && !job.rel) begin
                        val_next   = {job.num[vnem_pkg::OUT_W-ABS_SH-1:0], ABS_SH'(0)};
                        stat_next  = job.over ? STAT_SAT : STAT_OK;
                        state_next = ST_DONE;
                    end else if (!job.two_norm) begin
                        rem_next        = job.num >> LIN_SH;
                        shf_next        = {job.num[LIN_SH-1:0], (SHF_W - LIN_SH)'(0)};
                        den_next        = job.den;
                        quo_next        = '0;
                        iter_next       = ITER_W'(DIV_LIN);
                        sqrt_after_next = 1'b0;
                        state_next      = ST_DIV;
                    end else if (job.rel) begin
                        rem_next        = job.num >> TWO_SH;
                        shf_next        = {job.num[TWO_SH-1:0], (SHF_W - TWO_SH)'(0)};
                        den_next        = job.den;
                        quo_next        = '0;
                        iter_next       = ITER_W'(DIV_TWO);
                        sqrt_after_next = 1'b1;
                        state_next      = ST_DIV;
                    end else begin
                        shf_next    = {job.num[SHF_W-SQ_SH-1:0], SQ_SH'(0)};
                        sq_rem_next = '0;
                        root_next   = '0;
                        iter_next   = ITER_W'(SQ_STEPS);
                        state_next  = ST_SQRT;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? div_diff[REM_W-1:0] : div_r2[REM_W-1:0];
                quo_next  = quo_step;
                shf_next  = shf_reg << 1;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    if (sqrt_after_reg) begin
                        // Feed the quotient to the root unit
                        shf_next    = quo_step;
                        sq_rem_next = '0;
                        root_next   = '0;
                        iter_next   = ITER_W'(SQ_STEPS);
                        state_next  = ST_SQRT;
                    end else begin
                        val_next   = quo_step[vnem_pkg::OUT_W-1:0];
                        stat_next  = over_reg ? STAT_SAT : STAT_OK;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SQRT: begin
                sq_rem_next = sq_ge ? sq_diff[SQR_W-1:0] : sq_r2[SQR_W-1:0];
                root_next   = root_step;
                shf_next    = shf_reg << 2;
                iter_next   = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    val_next   = root_step;
                    stat_next  = over_reg ? STAT_SAT : STAT_OK;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = val_reg;
                    m_stat_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        shf_reg        <= shf_next;
        quo_reg        <= quo_next;
        sq_rem_reg     <= sq_rem_next;
        root_reg       <= root_next;
        iter_reg       <= iter_next;
        sqrt_after_reg <= sqrt_after_next;
        over_reg       <= over_next;
        val_reg        <= val_next;
        stat_reg       <= stat_next;
        m_value_reg    <= m_value_next;
        m_stat_reg     <= m_stat_next;
    end

endmodule

// File: hw/rtl/vector_norm_error_meter.sv
// Channel   Handshake            Word
// -------   -------------------  -----------------------------------------------
// input     s_valid / s_ready    s_approx_value, s_exact_value (Q12.12), s_last_item
// result    m_valid / m_ready    m_error_value (Q16.16), m_error_status
// config    cfg_we               cfg_addr (0 norm select, 1 relative mode), cfg_wdata
//
// Input words enter one per cycle, while s_ready is high, into a two-stage accumulate
// pipeline (abs, square, sum). A last word hands its sums to a two-entry job queue; the
// finish unit then handles an absolute one- or infinity-norm directly, a relative one- or
// infinity-norm with a 32-step divide, an absolute two-norm with a 32-step root, and a
// relative two-norm with a 64-step divide, then a 32-step root, plus the output drain wait.
// s_ready drops while queued jobs plus last words still in the pipeline fill the queue.
// Reset (aresetn low, synchronous) clears the sums, count, queue, output valid and sets
// norm select to two-norm, absolute mode.
module vector_norm_error_meter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [vnem_pkg::IN_W-1:0] s_approx_value,
    input  logic signed [vnem_pkg::IN_W-1:0] s_exact_value,
    input  logic                             s_last_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vnem_pkg::OUT_W-1:0]       m_error_value,
    output logic [vnem_pkg::STAT_W-1:0]      m_error_status,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [vnem_pkg::SEL_W-1:0]       cfg_wdata
);

    localparam logic CFG_NORM_SEL = 1'b0;
    localparam logic CFG_REL_MODE = 1'b1;

    logic [vnem_pkg::SEL_W-1:0] norm_sel_reg;
    logic                       rel_mode_reg;

    vnem_pkg::q_stat_t q_stat;
    vnem_pkg::job_t    push_job;
    vnem_pkg::job_t    head_job;
    logic              push;
    logic              pop;

    // Config registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_sel_reg <= vnem_pkg::NORM_TWO;
            rel_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_NORM_SEL: norm_sel_reg <= cfg_wdata;
                CFG_REL_MODE: rel_mode_reg <= cfg_wdata[0];
            endcase
        end
    end

    // Accumulate elements, emit one job per vector
    vnem_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_approx_value (s_approx_value),
        .s_exact_value  (s_exact_value),
        .s_last_item    (s_last_item),
        .norm_sel       (norm_sel_reg),
        .rel_mode       (rel_mode_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_job       (push_job)
    );

    // Hold finished vectors until the finish unit is free
    vnem_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (head_job),
        .q_stat   (q_stat)
    );

    // Divide, take the root, saturate and drive the result word
    vnem_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .job            (head_job),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_error_value  (m_error_value),
        .m_error_status (m_error_status)
    );

endmodule

// File: sim/vector_norm_error_meter_tb.sv
`timescale 1ns / 100ps

module vector_norm_error_meter_tb;

    // Register indexes, norm codes beyond the package's two, status codes
    localparam logic                           REG_NORM_SELECT = 1'b0;
    localparam logic                           REG_RELATIVE    = 1'b1;
    localparam logic [vnem_pkg::SEL_W-1:0]     NORM_INF        = 2'd2;
    localparam logic [vnem_pkg::SEL_W-1:0]     NORM_SPARE      = 2'd3;   // decodes as infinity-norm
    localparam logic [vnem_pkg::STAT_W-1:0]    ST_OK           = 2'd0;
    localparam logic [vnem_pkg::STAT_W-1:0]    ST_ZERO_DEN     = 2'd1;
    localparam logic [vnem_pkg::STAT_W-1:0]    ST_SAT          = 2'd2;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 120;   // covers the longest finish, the relative two-norm

    typedef enum int {STY_MIXED, STY_ZERO_EXACT, STY_TINY_EXACT, STY_FULL, STY_SMALL} vec_style_t;

    typedef struct packed {
        logic signed [vnem_pkg::IN_W-1:0] approx;
        logic signed [vnem_pkg::IN_W-1:0] exact;
        logic                             last;
    } pair_word_t;

    typedef struct packed {
        logic [vnem_pkg::OUT_W-1:0]  value;
        logic [vnem_pkg::STAT_W-1:0] status;
    } norm_err_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [vnem_pkg::IN_W-1:0] s_approx_value = '0;
    logic signed [vnem_pkg::IN_W-1:0] s_exact_value = '0;
    logic                             s_last_item = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [vnem_pkg::OUT_W-1:0]       m_error_value;
    logic [vnem_pkg::STAT_W-1:0]      m_error_status;
    logic                             cfg_we = 1'b0;
    logic                             cfg_addr = 1'b0;
    logic [vnem_pkg::SEL_W-1:0]       cfg_wdata = '0;

    // Words waiting for the sender, results waiting for the receiver
    pair_word_t  pair_pending[$];
    norm_err_t   err_due[$];
    pair_word_t  offer;
    norm_err_t   due;
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Idle control: chance in percent, per word offered or per ready cycle, of an idle burst
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    bit          want_hold = 1'b0;
    bit          hold_done = 1'b0;

    // Shadow of the block: configuration and running norm sums
    logic [vnem_pkg::SEL_W-1:0] sel_cfg = vnem_pkg::NORM_TWO;
    bit                         rel_cfg = 1'b0;
    logic [63:0]                dabs_acc = '0;
    logic [63:0]                eabs_acc = '0;
    logic [63:0]                dsq_acc = '0;
    logic [63:0]                esq_acc = '0;
    logic [63:0]                dmax_acc = '0;
    logic [63:0]                emax_acc = '0;
    int unsigned                elem_cnt = 0;

    vector_norm_error_meter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_approx_value (s_approx_value),
        .s_exact_value  (s_exact_value),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_error_value  (m_error_value),
        .m_error_status (m_error_status),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Integer square root, floor, built one result bit at a time from the top
    function automatic logic [31:0] root_floor(logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        int          i;
        r = '0;
        for (i = 31; i >= 0; i--) begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= x) r = t;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Fold one accepted word into the shadow sums; on a last word, queue
    // the error the block must return and clear the sums.
    task automatic absorb_pair(logic signed [vnem_pkg::IN_W-1:0] a,
                               logic signed [vnem_pkg::IN_W-1:0] e, logic last);
        logic signed [vnem_pkg::IN_W+1:0] d;
        logic signed [vnem_pkg::IN_W:0]   es;
        logic [63:0]                      ad;
        logic [63:0]                      ae;
        logic [63:0]                      num;
        logic [63:0]                      den;
        logic [127:0]                     quo;
        logic [vnem_pkg::OUT_W-1:0]       value;
        bit                               sat;
        bit                               zero_den;
        norm_err_t                        w;
        if (elem_cnt < vnem_pkg::MAX_ITEMS) begin
            d  = a - e;
            es = e;
            if (d < 0) d = -d;
            if (es < 0) es = -es;
            ad = 64'(d);
            ae = 64'(es);
            dabs_acc += ad;
            eabs_acc += ae;
            dsq_acc  += ad * ad;
            esq_acc  += ae * ae;
            if (ad > dmax_acc) dmax_acc = ad;
            if (ae > emax_acc) emax_acc = ae;
        end
        if (elem_cnt <= vnem_pkg::MAX_ITEMS) elem_cnt++;
        if (!last) return;

        sat      = (elem_cnt > vnem_pkg::MAX_ITEMS);   // overlong vector: truncated, flagged
        zero_den = 1'b0;
        value    = '0;
        quo      = '0;
        if (sel_cfg != vnem_pkg::NORM_TWO) begin
            num = (sel_cfg == vnem_pkg::NORM_ONE) ? dabs_acc : dmax_acc;
            den = (sel_cfg == vnem_pkg::NORM_ONE) ? eabs_acc : emax_acc;
            if (rel_cfg) begin
                if (den == 0) zero_den = 1'b1;
                else quo = {64'd0, num << 16} / {64'd0, den};
            end else begin
                quo = {64'd0, num << 4};
            end
            if (!zero_den) begin
                if (quo[127:32] != 0) begin
                    value = '1;
                    sat   = 1'b1;
                end else begin
                    value = quo[31:0];
                end
            end
        end else if (rel_cfg) begin
            if (esq_acc == 0) begin
                zero_den = 1'b1;
            end else begin
                quo = {32'd0, dsq_acc, 32'd0} / {64'd0, esq_acc};
                if (quo[127:64] != 0) begin
                    value = '1;
                    sat   = 1'b1;
                end else begin
                    value = root_floor(quo[63:0]);
                end
            end
        end else begin
            if (dsq_acc >= (64'd1 << 56)) begin
                value = '1;
                sat   = 1'b1;
            end else begin
                value = root_floor(dsq_acc << 8);
            end
        end

        // Zero denominator wins over saturation
        w.value  = zero_den ? '0 : value;
        w.status = zero_den ? ST_ZERO_DEN : (sat ? ST_SAT : ST_OK);
        err_due.push_back(w);
        dabs_acc = '0;
        eabs_acc = '0;
        dsq_acc  = '0;
        esq_acc  = '0;
        dmax_acc = '0;
        emax_acc = '0;
        elem_cnt = 0;
    endtask

    // Sender: hold the word until accepted, then advance to the next one or
    // drop valid for an idle burst.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_pair(s_approx_value, s_exact_value, s_last_item);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pair_pending.size() != 0) begin
                    offer = pair_pending.pop_front();
                    s_valid        <= 1'b1;
                    s_approx_value <= offer.approx;
                    s_exact_value  <= offer.exact;
                    s_last_item    <= offer.last;
                    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check every accepted result against the oldest expectation.
    // Ready drops for random bursts, and once for a long hold so the job
    // queue fills and the block stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (err_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    {m_error_status, m_error_value}, '0);
                end else begin
                    due = err_due.pop_front();
                    if (m_error_value !== due.value)
                        report_mismatch("error_value", m_error_value, due.value);
                    if (m_error_status !== due.status)
                        report_mismatch("error_status", m_error_status, due.status);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
                    sink_gap = $urandom_range(1, 19);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vector_norm_error_meter_tb NOT OK");
            $finish;
        end
    end

    task automatic push_pair(logic signed [vnem_pkg::IN_W-1:0] a,
                             logic signed [vnem_pkg::IN_W-1:0] e, logic last);
        pair_pending.push_back({a, e, last});
        words_queued++;
    endtask

    // Element spread: full range, extremes, and values scaled down by a shift
    function automatic logic signed [vnem_pkg::IN_W-1:0] pick_element();
        logic signed [vnem_pkg::IN_W-1:0] v;
        v = vnem_pkg::IN_W'($urandom);
        case ($urandom_range(0, 5))
            0: ;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 24'sh800000;
                    1: v = 24'sh7FFFFF;
                    2: v = 24'sh000000;
                    3: v = 24'shFFFFFF;
                    default: v = 24'sh000001;
                endcase
            end
            default: v = v >>> $urandom_range(0, 20);
        endcase
        return v;
    endfunction

    // An approximation: equal, a small error off, or unrelated
    function automatic logic signed [vnem_pkg::IN_W-1:0] pick_approx(
            logic signed [vnem_pkg::IN_W-1:0] e);
        logic signed [vnem_pkg::IN_W-1:0] delta;
        delta = vnem_pkg::IN_W'($urandom);
        delta = delta >>> $urandom_range(6, 23);
        case ($urandom_range(0, 3))
            0: return e;
            3: return pick_element();
            default: return e + delta;
        endcase
    endfunction

    function automatic vec_style_t pick_style();
        case ($urandom_range(0, 9))
            0: return STY_ZERO_EXACT;
            1: return STY_TINY_EXACT;
            2: return STY_FULL;
            3: return STY_SMALL;
            default: return STY_MIXED;
        endcase
    endfunction

    task automatic queue_vector(int unsigned len, vec_style_t style);
        logic signed [vnem_pkg::IN_W-1:0] a;
        logic signed [vnem_pkg::IN_W-1:0] e;
        int unsigned                      k;
        for (k = 0; k < len; k++) begin
            case (style)
                STY_ZERO_EXACT: begin
                    e = '0;
                    a = pick_element();
                end
                STY_TINY_EXACT: begin
                    e = vnem_pkg::IN_W'($urandom_range(0, 2)) - 24'sd1;
                    a = vnem_pkg::IN_W'($urandom);
                end
                STY_FULL: begin
                    e = vnem_pkg::IN_W'($urandom);
                    a = vnem_pkg::IN_W'($urandom);
                end
                STY_SMALL: begin
                    e = vnem_pkg::IN_W'($urandom);
                    a = vnem_pkg::IN_W'($urandom);
                    e = e >>> 10;
                    a = a >>> 10;
                end
                default: begin
                    e = pick_element();
                    a = pick_approx(e);
                end
            endcase
            push_pair(a, e, k == len - 1);
        end
    endtask

    // Wait until every word is taken and every result is back, then let
    // the finish unit run out before touching the registers.
    task automatic settle();
        while (words_taken != words_queued || err_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [vnem_pkg::SEL_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_NORM_SELECT) sel_cfg = val;
        else rel_cfg = val[0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One setting of the registers with random vectors behind it. Open with
    // a zero-exact and a tiny-exact vector so the relative modes always see
    // a zero denominator and usually an overflowing quotient.
    task automatic run_phase(logic [vnem_pkg::SEL_W-1:0] sel, bit rel, int unsigned budget,
                             int unsigned max_len, int unsigned src_pct,
                             int unsigned sink_pct, bit hold, int unsigned long_len,
                             vec_style_t long_style);
        int unsigned start;
        int unsigned len;
        settle();
        write_reg(REG_NORM_SELECT, sel);
        write_reg(REG_RELATIVE, {1'b0, rel});
        @(negedge aclk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        if (hold) want_hold = 1'b1;
        start = words_queued;
        queue_vector($urandom_range(1, max_len), STY_ZERO_EXACT);
        queue_vector($urandom_range(1, max_len), STY_TINY_EXACT);
        while (words_queued - start < budget) begin
            len = $urandom_range(1, max_len);
            if (max_len > 2 && $urandom_range(0, 9) == 0) len = $urandom_range(16, 40);
            queue_vector(len, pick_style());
        end
        if (long_len != 0) queue_vector(long_len, long_style);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset setting (absolute two-norm): field extremes, zero and equal
        // vectors, a small difference across zero, two short mixed vectors.
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        push_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
        push_pair(24'sh800000, 24'sh7FFFFF, 1'b1);
        push_pair(24'sh000000, 24'sh000000, 1'b1);
        push_pair(24'sh800000, 24'sh800000, 1'b1);
        push_pair(24'sh000001, 24'shFFFFFF, 1'b1);
        push_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        push_pair(24'sh800000, 24'sh000000, 1'b0);
        push_pair(24'sh123456, 24'shFFFFFB, 1'b1);
        push_pair(24'shFFFFFF, 24'sh000000, 1'b0);
        push_pair(24'sh555555, 24'shAAAAAA, 1'b1);

        // Sweep the settings with short vectors
        run_phase(vnem_pkg::NORM_ONE, 1'b0, 8,  6, 20, 5,  1'b0, 0, STY_MIXED);
        run_phase(vnem_pkg::NORM_ONE, 1'b1, 8,  6, 0,  20, 1'b0, 0, STY_MIXED);
        // Long receiver hold with one- and two-word vectors: fill the job queue
        run_phase(vnem_pkg::NORM_TWO, 1'b1, 16, 2, 5,  5,  1'b1, 0, STY_MIXED);
        run_phase(NORM_INF,           1'b0, 8,  6, 20, 20, 1'b0, 0, STY_MIXED);
        run_phase(NORM_INF,           1'b1, 8,  6, 0,  0,  1'b0, 0, STY_MIXED);
        run_phase(NORM_SPARE,         1'b0, 8,  6, 5,  20, 1'b0, 0, STY_MIXED);
        run_phase(NORM_SPARE,         1'b1, 8,  6, 20, 0,  1'b0, 0, STY_MIXED);
        // Closing phase without idling; finish on an overlong full-range
        // vector: only its first MAX_ITEMS elements count and the status
        // flags saturation.
        run_phase(vnem_pkg::NORM_TWO, 1'b0, 8,  6, 0,  0,  1'b0,
                  vnem_pkg::MAX_ITEMS + 1 + $urandom_range(0, 4), STY_FULL);

        settle();
        if (mismatch_count == 0) begin
            $display("vector_norm_error_meter_tb OK");
        end else begin
            $display("vector_norm_error_meter_tb NOT OK");
        end
        $finish;
    end

endmodule
